// ----- hdl/u16u8_pkg.sv -----
// Shared types, constants and the UTF-8 encoder for the UTF-16 to UTF-8 transcoder.
`default_nettype none
package u16u8_pkg;

  localparam logic [7:0] BOM_FE = 8'hFE;
  localparam logic [7:0] BOM_FF = 8'hFF;

  // top six bits of a surrogate code unit
  localparam logic [5:0] SURR_LEAD  = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0] SURR_TRAIL = 6'b110111;  // 0xDC00..0xDFFF

  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // encoder result: up to four bytes, count 0..4
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } u16u8_enc_t;

  // one queued entry: bytes of one item, ready for the serializer
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt_m1;  // number of results minus one
    logic            bare;    // end marker without a byte
    logic            last;    // item closed the text
    logic            halted;  // conversion stopped on an unpaired lead
  } u16u8_entry_t;

  function automatic u16u8_enc_t utf8_encode(input logic [20:0] cp);
    u16u8_enc_t e;
    e.bytes = '0;
    e.cnt   = 3'd0;
    if (cp < 21'h20) begin
      e.cnt = 3'd0;
    end else if (cp < 21'h80) begin
      e.bytes[0] = cp[7:0];
      e.cnt      = 3'd1;
    end else if (cp < 21'h800) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.cnt      = 3'd2;
    end else if (cp < SUPP_BASE) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.cnt      = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.cnt      = 3'd4;
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/u16u8_front.sv -----
// Front end: accepts code units, tracks byte order and surrogates, encodes to UTF-8.
`default_nettype none
module u16u8_front
  import u16u8_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic [7:0]   first_byte,
  input  wire logic [7:0]   second_byte,
  input  wire logic         last_unit,
  output logic              push,
  output u16u8_entry_t      entry
);

  logic       in_prefix_r, in_prefix_nxt;
  logic       little_endian_r, little_endian_nxt;
  logic       lead_held_r, lead_held_nxt;
  logic [9:0] held_lead_bits_r, held_lead_bits_nxt;
  logic       halted_r, halted_nxt;

  logic        bom_le, bom_be, skip, work;
  logic [15:0] unit;
  logic [20:0] cp;
  logic        do_enc;
  u16u8_enc_t  enc;

  always_comb begin
    bom_le = (first_byte == BOM_FF) && (second_byte == BOM_FE);
    bom_be = (first_byte == BOM_FE) && (second_byte == BOM_FF);
    skip   = !halted_r && in_prefix_r && (bom_le || bom_be);
    work   = !halted_r && !skip;
    unit   = little_endian_r ? {second_byte, first_byte} : {first_byte, second_byte};

    in_prefix_nxt      = in_prefix_r;
    little_endian_nxt  = little_endian_r;
    lead_held_nxt      = lead_held_r;
    held_lead_bits_nxt = held_lead_bits_r;
    halted_nxt         = halted_r;
    do_enc             = 1'b0;
    cp                 = {5'd0, unit};

    if (!halted_r && in_prefix_r) begin
      if (bom_le || bom_be) begin
        little_endian_nxt = bom_le;
      end else begin
        in_prefix_nxt = 1'b0;
      end
    end

    if (work) begin
      if (lead_held_r) begin
        if (unit[15:10] == SURR_TRAIL) begin
          cp                 = {1'b0, held_lead_bits_r, unit[9:0]} + SUPP_BASE;
          lead_held_nxt      = 1'b0;
          held_lead_bits_nxt = '0;
          do_enc             = 1'b1;
        end else begin
          halted_nxt = 1'b1;
        end
      end else if (unit[15:10] == SURR_LEAD) begin
        if (last_unit) begin
          halted_nxt = 1'b1;
        end else begin
          lead_held_nxt      = 1'b1;
          held_lead_bits_nxt = unit[9:0];
        end
      end else begin
        do_enc = 1'b1;
      end
    end

    enc = utf8_encode(cp);
    if (!do_enc) begin
      enc = '0;
    end

    entry.bytes  = enc.bytes;
    entry.bare   = (enc.cnt == 3'd0);
    entry.cnt_m1 = (enc.cnt == 3'd0) ? 2'd0 : 2'(enc.cnt - 3'd1);
    entry.last   = last_unit;
    entry.halted = halted_nxt;
    push         = accept && ((enc.cnt != 3'd0) || last_unit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_prefix_r      <= 1'b1;
      little_endian_r  <= 1'b0;
      lead_held_r      <= 1'b0;
      held_lead_bits_r <= '0;
      halted_r         <= 1'b0;
    end else if (accept) begin
      if (last_unit) begin
        in_prefix_r      <= 1'b1;
        little_endian_r  <= 1'b0;
        lead_held_r      <= 1'b0;
        held_lead_bits_r <= '0;
        halted_r         <= 1'b0;
      end else begin
        in_prefix_r      <= in_prefix_nxt;
        little_endian_r  <= little_endian_nxt;
        lead_held_r      <= lead_held_nxt;
        held_lead_bits_r <= held_lead_bits_nxt;
        halted_r         <= halted_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/u16u8_fifo.sv -----
// Short queue of encoded entries between front end and serializer.
`default_nettype none
module u16u8_fifo
  import u16u8_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire u16u8_entry_t  wr_data,
  input  wire logic          rd_en,
  output u16u8_entry_t       rd_data,
  output logic               full,
  output logic               empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  u16u8_entry_t slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/u16u8_back.sv -----
// Back end: serializes entries into a registered byte per cycle unless stalled.
`default_nettype none
module u16u8_back
  import u16u8_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire u16u8_entry_t  head,
  input  wire logic          head_valid,
  output logic               pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  output logic [2:0]         out_tuser
);

  logic       valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic       last_run_r, last_run_nxt;
  logic [2:0] user_r, user_nxt;
  logic [1:0] idx_r;
  logic       load, fin;

  always_comb begin
    load         = head_valid && (!valid_r || out_tready);
    fin          = (idx_r == head.cnt_m1);
    pop          = load && fin;
    byte_nxt     = head.bare ? 8'd0 : head.bytes[idx_r];
    last_run_nxt = fin;
    user_nxt     = {head.halted, fin && head.last, !head.bare};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r     <= byte_nxt;
      last_run_r <= last_run_nxt;
      user_r     <= user_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= fin ? 2'd0 : idx_r + 2'd1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_run_r;
  assign out_tuser  = user_r;

endmodule
`default_nettype wire

// ----- hdl/utf16_to_utf8_transcoder_core.sv -----
// Top level of the UTF-16 to UTF-8 transcoder: front end, entry queue, byte serializer.
//
//   channel | dir | ports                        | contents
//   --------+-----+------------------------------+------------------------------------
//   in_     | in  | tvalid tready tdata tlast    | one UTF-16 code unit as two bytes
//   out_    | out | tvalid tready tdata tlast    | one UTF-8 byte or a bare end marker
//           |     | tuser                        |
//
// A unit is decoded in the cycle it is taken and queued at that edge; its results then
// pass to the output register, one per cycle unless stalled, 1 to 4 per item (its UTF-8
// length, or 1 for an end marker); units with no result are not queued.
// Reset: synchronous on rst_n low; clears text state, queue pointers, output valid.
// Stalls: in_tready drops only when the queue is full; out_tready low holds the
// output register while the front end keeps filling the queue.
`default_nettype none
module utf16_to_utf8_transcoder_core
  import u16u8_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] first_byte, [15:8] second_byte
  input  wire logic        in_tlast,   // last_unit
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,  // last_of_run
  output logic [2:0]       out_tuser   // [0] byte_valid, [1] text_end, [2] stopped_on_error
);

  logic         accept;
  logic         push;
  u16u8_entry_t front_entry;
  u16u8_entry_t head;
  logic         q_full, q_empty, pop;

  // queue full is the only thing that backs up the input
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  u16u8_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .first_byte  (in_tdata[7:0]),
    .second_byte (in_tdata[15:8]),
    .last_unit   (in_tlast),
    .push        (push),
    .entry       (front_entry)
  );

  u16u8_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_entry),
    .rd_en   (pop),
    .rd_data (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
